### sv/lrc_pkg.sv
// lrc_pkg: shared types, constants and codes for the lru result cache
// depends on nothing; used by every other file of the block but lrc_if

package lrc_pkg;

    localparam int ENTRIES_DEFAULT = 64;
    localparam int CAP_W           = 7;
    localparam int KEY_W           = 64;

    localparam logic [1:0] MODE_LOOKUP = 2'd0;
    localparam logic [1:0] MODE_STORE  = 2'd1;
    localparam logic [1:0] MODE_CLEAR  = 2'd2;
    localparam logic [1:0] MODE_NONE   = 2'd3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MATCH,
        ST_DECIDE,
        ST_EVICT,
        ST_OUT
    } lrc_state_t;

    // controller to datapath
    typedef struct packed {
        logic load;     // capture input beat
        logic match;    // register compare results
        logic promote;  // make hit slot most recent
        logic wr_hit;   // rewrite verdict of hit slot
        logic evict;    // drop the least recent entry
        logic insert;   // insert key as most recent
        logic clear;    // drop every entry
    } lrc_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic [1:0] mode;
        logic       hit;
        logic       full;   // count at or above effective capacity, count > 0
    } lrc_stat_t;

endpackage

### sv/lrc_if.sv
// lrc_if: valid/ready channel interfaces for request and response beats
// depends on nothing

interface lrc_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  mode;
    logic [63:0] key_word0;
    logic [63:0] key_word1;
    logic [63:0] key_word2;
    logic [63:0] key_word3;
    logic        verdict_in;
    modport source (output valid, mode, key_word0, key_word1, key_word2, key_word3,
                    verdict_in, input ready);
    modport sink   (input valid, mode, key_word0, key_word1, key_word2, key_word3,
                    verdict_in, output ready);
endinterface

interface lrc_rsp_if;
    logic       valid;
    logic       ready;
    logic       hit;
    logic       verdict_out;
    logic [6:0] occupancy;
    modport source (output valid, hit, verdict_out, occupancy, input ready);
    modport sink   (input valid, hit, verdict_out, occupancy, output ready);
endinterface

### sv/lru_result_cache.sv
// lru_result_cache: top level, joins sequencer and entry datapath
// depends on lrc_pkg, lrc_if, lrc_ctrl, lrc_data
//
//  channel  dir  beat
//  req      in   mode, key_word0..3, verdict_in
//  rsp      out  hit, verdict_out, occupancy
//  cfg      in   cfg_we, cfg_wdata (capacity)
//
// one request at a time: the match and decide states run before the response beat is
// offered; a store of a new key into a full cache adds the evict state until below capacity
// the response is held until taken; the next request is accepted after it
// reset clears valid bits and count at once, capacity returns to 64

module lru_result_cache
#(
    parameter int ENTRIES = lrc_pkg::ENTRIES_DEFAULT
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic [lrc_pkg::CAP_W-1:0] cfg_wdata,
    lrc_req_if.sink                   req,
    lrc_rsp_if.source                 rsp
);
    import lrc_pkg::*;

    lrc_cmd_t  cmd;
    lrc_stat_t stat;

    lrc_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_ready  (req.ready),
        .out_valid (rsp.valid),
        .out_ready (rsp.ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    lrc_data #(.ENTRIES(ENTRIES)) u_data
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .mode        (req.mode),
        .key_word0   (req.key_word0),
        .key_word1   (req.key_word1),
        .key_word2   (req.key_word2),
        .key_word3   (req.key_word3),
        .verdict_in  (req.verdict_in),
        .cmd         (cmd),
        .stat        (stat),
        .hit         (rsp.hit),
        .verdict_out (rsp.verdict_out),
        .occupancy   (rsp.occupancy)
    );

endmodule

### sv/lrc_ctrl.sv
// lrc_ctrl: operation sequencer for the lru result cache
// depends on lrc_pkg

module lrc_ctrl
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    output logic               out_valid,
    input  logic               out_ready,
    input  lrc_pkg::lrc_stat_t stat,
    output lrc_pkg::lrc_cmd_t  cmd
);
    import lrc_pkg::*;

    lrc_state_t state_reg, state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        out_valid  = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_MATCH;
                end
            end
            ST_MATCH:
            begin
                cmd.match  = 1'b1;
                state_next = ST_DECIDE;
            end
            ST_DECIDE:
            begin
                state_next = ST_OUT;
                case (stat.mode)
                    MODE_LOOKUP:
                    begin
                        cmd.promote = stat.hit;
                    end
                    MODE_STORE:
                    begin
                        if (stat.hit)
                        begin
                            cmd.promote = 1'b1;
                            cmd.wr_hit  = 1'b1;
                        end
                        else if (stat.full)
                        begin
                            cmd.evict  = 1'b1;
                            state_next = ST_EVICT;
                        end
                        else
                        begin
                            cmd.insert = 1'b1;
                        end
                    end
                    MODE_CLEAR:
                    begin
                        cmd.clear = 1'b1;
                    end
                    default:
                    begin
                    end
                endcase
            end
            ST_EVICT:
            begin
                // one eviction a cycle until below capacity
                if (stat.full)
                begin
                    cmd.evict = 1'b1;
                end
                else
                begin
                    cmd.insert = 1'b1;
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                out_valid = 1'b1;
                if (out_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

### sv/lrc_data.sv
// lrc_data: entry store, key compare, recency ranks and occupancy
// depends on lrc_pkg

module lrc_data
#(
    parameter int ENTRIES = lrc_pkg::ENTRIES_DEFAULT
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic [lrc_pkg::CAP_W-1:0] cfg_wdata,
    input  logic [1:0]                mode,
    input  logic [lrc_pkg::KEY_W-1:0] key_word0,
    input  logic [lrc_pkg::KEY_W-1:0] key_word1,
    input  logic [lrc_pkg::KEY_W-1:0] key_word2,
    input  logic [lrc_pkg::KEY_W-1:0] key_word3,
    input  logic                      verdict_in,
    input  lrc_pkg::lrc_cmd_t         cmd,
    output lrc_pkg::lrc_stat_t        stat,
    output logic                      hit,
    output logic                      verdict_out,
    output logic [lrc_pkg::CAP_W-1:0] occupancy
);
    import lrc_pkg::*;

    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W = $clog2(ENTRIES + 1);
    localparam int RNK_W = IDX_W;
    localparam int CW    = (CNT_W > CAP_W) ? CNT_W : CAP_W;

    logic [KEY_W-1:0] key0_reg [ENTRIES];
    logic [KEY_W-1:0] key1_reg [ENTRIES];
    logic [KEY_W-1:0] key2_reg [ENTRIES];
    logic [KEY_W-1:0] key3_reg [ENTRIES];
    logic [ENTRIES-1:0] verd_reg;
    logic [ENTRIES-1:0] valid_reg;
    logic [RNK_W-1:0] rank_reg [ENTRIES];
    logic [CNT_W-1:0] count_reg;
    logic [CAP_W-1:0] cap_reg;

    logic [1:0]       mode_reg;
    logic [KEY_W-1:0] k0_reg, k1_reg, k2_reg, k3_reg;
    logic             vin_reg;
    logic             hit_reg;
    logic [IDX_W-1:0] slot_reg;
    logic             hverd_reg;
    logic             rhit_reg, rverd_reg;

    // capacity register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg <= CAP_W'(64);
        end
        else if (cfg_we)
        begin
            cap_reg <= cfg_wdata;
        end
    end

    // input beat capture
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            mode_reg <= mode;
            k0_reg   <= key_word0;
            k1_reg   <= key_word1;
            k2_reg   <= key_word2;
            k3_reg   <= key_word3;
            vin_reg  <= verdict_in;
        end
    end

    // parallel compare against every valid entry
    logic [ENTRIES-1:0] eq;
    always_comb
    begin
        for (int i = 0; i < ENTRIES; i++)
        begin
            eq[i] = valid_reg[i] && key0_reg[i] == k0_reg && key1_reg[i] == k1_reg
                    && key2_reg[i] == k2_reg && key3_reg[i] == k3_reg;
        end
    end

    logic [IDX_W-1:0] eq_idx;
    always_comb
    begin
        eq_idx = '0;
        for (int i = ENTRIES - 1; i >= 0; i--)
        begin
            if (eq[i])
            begin
                eq_idx = IDX_W'(i);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.match)
        begin
            hit_reg   <= |eq;
            slot_reg  <= eq_idx;
            hverd_reg <= verd_reg[eq_idx];
        end
    end

    // effective capacity, clamped to 1..ENTRIES
    logic [CW-1:0] cap_eff;
    always_comb
    begin
        cap_eff = CW'(cap_reg);
        if (cap_eff == '0)
        begin
            cap_eff = CW'(1);
        end
        if (cap_eff > CW'(ENTRIES))
        begin
            cap_eff = CW'(ENTRIES);
        end
    end

    // oldest entry and first free slot
    logic [ENTRIES-1:0] old_m, free_m;
    logic [IDX_W-1:0]   free_idx;
    always_comb
    begin
        for (int i = 0; i < ENTRIES; i++)
        begin
            old_m[i]  = valid_reg[i] && CNT_W'(rank_reg[i]) == count_reg - CNT_W'(1);
            free_m[i] = !valid_reg[i];
        end
        free_idx = '0;
        for (int i = ENTRIES - 1; i >= 0; i--)
        begin
            if (free_m[i])
            begin
                free_idx = IDX_W'(i);
            end
        end
    end

    // entry state update
    logic [RNK_W-1:0] hit_rank;
    assign hit_rank = rank_reg[slot_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            count_reg <= '0;
        end
        else if (cmd.clear)
        begin
            valid_reg <= '0;
            count_reg <= '0;
        end
        else if (cmd.evict)
        begin
            valid_reg <= valid_reg & ~old_m;
            count_reg <= count_reg - CNT_W'(1);
        end
        else if (cmd.insert)
        begin
            valid_reg[free_idx] <= 1'b1;
            count_reg <= count_reg + CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < ENTRIES; i++)
        begin
            if (cmd.promote && valid_reg[i] && rank_reg[i] < hit_rank)
            begin
                rank_reg[i] <= rank_reg[i] + RNK_W'(1);
            end
            if (cmd.insert && valid_reg[i])
            begin
                rank_reg[i] <= rank_reg[i] + RNK_W'(1);
            end
        end
        if (cmd.promote)
        begin
            rank_reg[slot_reg] <= '0;
        end
        if (cmd.wr_hit)
        begin
            verd_reg[slot_reg] <= vin_reg;
        end
        if (cmd.insert)
        begin
            key0_reg[free_idx] <= k0_reg;
            key1_reg[free_idx] <= k1_reg;
            key2_reg[free_idx] <= k2_reg;
            key3_reg[free_idx] <= k3_reg;
            verd_reg[free_idx] <= vin_reg;
            rank_reg[free_idx] <= '0;
        end
    end

    // result fields, fixed at decision time
    always_ff @(posedge clk)
    begin
        if (cmd.match)
        begin
            rhit_reg  <= 1'b0;
            rverd_reg <= 1'b0;
        end
        else if (cmd.promote && mode_reg == MODE_LOOKUP)
        begin
            rhit_reg  <= 1'b1;
            rverd_reg <= hverd_reg;
        end
    end

    assign stat.mode   = mode_reg;
    assign stat.hit    = hit_reg;
    assign stat.full   = (CW'(count_reg) >= cap_eff) && (count_reg != '0);
    assign hit         = rhit_reg;
    assign verdict_out = rverd_reg;
    assign occupancy   = CAP_W'(count_reg);

endmodule

### verif/tb_scoreboard.sv
// tb_scoreboard: lru cache predictor and response checker for the testbench
// depends on lrc_pkg for operation codes

`timescale 1ns / 100ps

class lru_cache_scoreboard;
    typedef struct packed {
        logic       hit;
        logic       verdict;
        logic [6:0] occupancy;
    } cache_resp_t;

    logic [255:0] slot_key [64];
    logic         slot_verdict [64];
    logic         slot_live [64];
    int           slot_age [64];
    int           live_count;
    int           cap_reg;
    cache_resp_t  pending [$];
    int           errors;

    function new();
        errors = 0;
        cap_reg = 64;
        live_count = 0;
        for (int i = 0; i < 64; i++)
        begin
            slot_live[i] = 0;
            slot_age[i] = 0;
        end
    endfunction

    function void set_capacity(logic [6:0] v);
        cap_reg = v;
    endfunction

    function int lookup_slot(logic [255:0] k);
        for (int i = 0; i < 64; i++)
            if (slot_live[i] && slot_key[i] == k)
                return i;
        return -1;
    endfunction

    function void make_recent(int s);
        int r;
        r = slot_age[s];
        for (int i = 0; i < 64; i++)
            if (slot_live[i] && slot_age[i] < r)
                slot_age[i]++;
        slot_age[s] = 0;
    endfunction

    // note an accepted request beat and predict its response
    function void note_request(logic [1:0] mode, logic [255:0] k, logic v);
        cache_resp_t r;
        int s;
        int cap;
        int free_slot;
        r = '0;
        if (mode == lrc_pkg::MODE_LOOKUP)
        begin
            s = lookup_slot(k);
            if (s >= 0)
            begin
                make_recent(s);
                r.hit = 1;
                r.verdict = slot_verdict[s];
            end
        end
        else if (mode == lrc_pkg::MODE_STORE)
        begin
            s = lookup_slot(k);
            if (s >= 0)
            begin
                slot_verdict[s] = v;
                make_recent(s);
            end
            else
            begin
                cap = (cap_reg == 0) ? 1 : (cap_reg > 64 ? 64 : cap_reg);
                // evict least recent until below capacity
                while (live_count >= cap && live_count > 0)
                begin
                    for (int i = 0; i < 64; i++)
                        if (slot_live[i] && slot_age[i] == live_count - 1)
                        begin
                            slot_live[i] = 0;
                            break;
                        end
                    live_count--;
                end
                free_slot = -1;
                for (int i = 0; i < 64; i++)
                    if (slot_live[i])
                        slot_age[i]++;
                    else if (free_slot < 0)
                        free_slot = i;
                slot_key[free_slot] = k;
                slot_verdict[free_slot] = v;
                slot_live[free_slot] = 1;
                slot_age[free_slot] = 0;
                live_count++;
            end
        end
        else if (mode == lrc_pkg::MODE_CLEAR)
        begin
            for (int i = 0; i < 64; i++)
                slot_live[i] = 0;
            live_count = 0;
        end
        r.occupancy = 7'(live_count);
        pending.push_back(r);
    endfunction

    // compare a response beat with the oldest prediction
    function void check_response(logic hit, logic verdict, logic [6:0] occ);
        cache_resp_t e;
        if (pending.size() == 0)
        begin
            $display("%0t: unexpected response hit=%0d verdict=%0d occupancy=%0d",
                     $time, hit, verdict, occ);
            errors++;
            return;
        end
        e = pending.pop_front();
        if (hit !== e.hit)
        begin
            $display("%0t: hit expected %0d actual %0d", $time, e.hit, hit);
            errors++;
        end
        if (verdict !== e.verdict)
        begin
            $display("%0t: verdict expected %0d actual %0d", $time, e.verdict, verdict);
            errors++;
        end
        if (occ !== e.occupancy)
        begin
            $display("%0t: occupancy expected %0d actual %0d", $time, e.occupancy, occ);
            errors++;
        end
    endfunction
endclass

### verif/tb_top.sv
// tb_top: drives the lru result cache with directed and random beats
// depends on lrc_pkg, lrc_if, lru_result_cache and tb_scoreboard

`timescale 1ns / 100ps

module tb_top;
    import lrc_pkg::*;

    logic       clk;
    logic       rst_n;
    logic       cfg_we;
    logic [6:0] cfg_wdata;

    lrc_req_if req ();
    lrc_rsp_if rsp ();

    lru_result_cache uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .req       (req.sink),
        .rsp       (rsp.source)
    );

    lru_cache_scoreboard board;
    logic [255:0] key_pool [16];
    int  hold_off_cycles;
    bit  calm_sink;
    bit  calm_source;

    // clock
    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    // timeout
    initial
    begin
        #20ms;
        $display("tb_top: FAIL");
        $finish;
    end

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    // response side: random stalls, long hold-offs on request
    initial
    begin
        rsp.ready = 0;
        @(posedge clk iff rst_n);
        forever
        begin
            @(posedge clk);
            if (rsp.valid && rsp.ready)
                board.check_response(rsp.hit, rsp.verdict_out, rsp.occupancy);
            if (hold_off_cycles > 0)
            begin
                hold_off_cycles--;
                rsp.ready <= 0;
            end
            else
                rsp.ready <= calm_sink ? 1'b1 : ($urandom_range(99) >= 19);
        end
    end

    // send one request beat, with a random gap first unless calm_source is set
    task automatic send_beat(logic [1:0] mode, logic [255:0] k, logic v);
        while (!calm_source && $urandom_range(99) < 19)
        begin
            req.valid <= 0;
            @(posedge clk);
        end
        req.valid      <= 1;
        req.mode       <= mode;
        req.key_word0  <= k[63:0];
        req.key_word1  <= k[127:64];
        req.key_word2  <= k[191:128];
        req.key_word3  <= k[255:192];
        req.verdict_in <= v;
        @(posedge clk);
        while (!req.ready)
            @(posedge clk);
        board.note_request(mode, k, v);
    endtask

    task automatic drain();
        req.valid <= 0;
        @(posedge clk);
        while (board.pending.size() != 0)
            @(posedge clk);
        repeat (80) @(posedge clk);
    endtask

    task automatic write_capacity(logic [6:0] v);
        drain();
        cfg_we    <= 1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we    <= 0;
        board.set_capacity(v);
    endtask

    // random phase: mostly pool keys, some fresh keys and noise modes
    task automatic random_phase(int n);
        logic [255:0] k;
        logic [1:0]   m;
        int sel;
        for (int i = 0; i < n; i++)
        begin
            sel = $urandom_range(99);
            if (sel < 3)
                m = MODE_NONE;
            else if (sel < 6)
                m = MODE_CLEAR;
            else if (sel < 50)
                m = MODE_LOOKUP;
            else
                m = MODE_STORE;
            if ($urandom_range(9) < 8)
                k = key_pool[$urandom_range(15)];
            else
                k = {rand64(), rand64(), rand64(), rand64()};
            send_beat(m, k, 1'($urandom_range(1)));
        end
    endtask

    initial
    begin
        board = new();
        hold_off_cycles = 0;
        calm_sink = 0;
        calm_source = 0;
        rst_n = 0;
        cfg_we = 0;
        cfg_wdata = 7'd64;
        req.valid = 0;
        req.mode = MODE_LOOKUP;
        req.key_word0 = '0;
        req.key_word1 = '0;
        req.key_word2 = '0;
        req.key_word3 = '0;
        req.verdict_in = 0;
        for (int i = 0; i < 16; i++)
            key_pool[i] = {rand64(), rand64(), rand64(), rand64()};
        key_pool[0] = '0;
        key_pool[1] = '1;
        repeat (2) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // directed: extremes of keys, every mode, capacity corners
        send_beat(MODE_LOOKUP, key_pool[0], 0);
        send_beat(MODE_STORE, key_pool[0], 1);
        send_beat(MODE_STORE, key_pool[1], 0);
        send_beat(MODE_LOOKUP, key_pool[0], 0);
        send_beat(MODE_LOOKUP, key_pool[1], 1);
        send_beat(MODE_STORE, key_pool[1], 1);
        send_beat(MODE_LOOKUP, key_pool[1], 0);
        send_beat(MODE_NONE, key_pool[2], 1);
        send_beat(MODE_STORE, key_pool[2], 0);
        write_capacity(7'd1);
        send_beat(MODE_STORE, key_pool[3], 1);
        send_beat(MODE_LOOKUP, key_pool[0], 0);
        send_beat(MODE_LOOKUP, key_pool[3], 0);
        write_capacity(7'd0);
        send_beat(MODE_STORE, key_pool[4], 1);
        send_beat(MODE_STORE, key_pool[5], 0);
        write_capacity(7'd127);
        send_beat(MODE_STORE, key_pool[6], 1);
        send_beat(MODE_CLEAR, key_pool[6], 0);
        send_beat(MODE_LOOKUP, key_pool[6], 0);

        // fill to full capacity, then lower capacity below occupancy
        write_capacity(7'd64);
        calm_source = 1;
        for (int i = 0; i < 70; i++)
        begin
            if (i == 10)
                hold_off_cycles = 300;
            send_beat(MODE_STORE, {rand64(), rand64(), rand64(), rand64()},
                      1'($urandom_range(1)));
        end
        calm_source = 0;
        write_capacity(7'd3);
        send_beat(MODE_STORE, key_pool[7], 1);
        send_beat(MODE_LOOKUP, key_pool[7], 0);

        // random phases over several capacities
        write_capacity(7'd8);
        random_phase(300);
        write_capacity(7'd2);
        random_phase(200);
        calm_sink = 1;
        calm_source = 1;
        write_capacity(7'd12);
        random_phase(250);
        calm_sink = 0;
        calm_source = 0;
        write_capacity(7'd64);
        random_phase(300);
        write_capacity(7'd5);
        random_phase(150);

        drain();
        if (board.errors == 0 && board.pending.size() == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end
endmodule
